// ----- rtl/pstt_pkg.sv -----
package pstt_pkg;

    localparam int ID_W    = 16;
    localparam int FCNT_W  = 12;
    localparam int SCNT_W  = 7;
    localparam int KIND_W  = 2;
    localparam int REQ_W   = 3;
    localparam int MS_W    = 16;
    localparam int MAXRES  = 32;

    localparam logic [REQ_W-1:0] REQ_TICK20   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK1S   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REG      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UNREG    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REG_RT   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNREG_RT = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RESET_RT = 3'd7;

    localparam logic [KIND_W-1:0] EV_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] EV_POSTED  = 2'd1;
    localparam logic [KIND_W-1:0] EV_RT      = 2'd2;

    // Operation applied by a cell to the slot passing through it
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_CLRID = 3'd3;
    localparam logic [2:0] OP_CLRCT = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [FCNT_W-1:0] count;
        logic [FCNT_W-1:0] period;
    } slot_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [FCNT_W-1:0] cmax;
        logic [FCNT_W-1:0] period;
        logic [ID_W-1:0]   id;
        logic              hit;
    } cell_ctl_t;

endpackage

// ----- rtl/pstt_cell.sv -----
module pstt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  pstt_pkg::cell_ctl_t ctl,
    input  pstt_pkg::slot_t     in_slot,
    output pstt_pkg::slot_t     out_slot,
    output logic                fire
);

    pstt_pkg::slot_t slot_reg;
    pstt_pkg::slot_t slot_next;
    logic [pstt_pkg::FCNT_W-1:0] cnt_inc;

    assign out_slot = slot_reg;

    // Work on the head slot and pass it back into the tail of the ring
    always_comb
    begin
        slot_next = in_slot;
        cnt_inc   = (in_slot.count < ctl.cmax) ? in_slot.count + 1'b1 : in_slot.count;
        fire      = 1'b0;
        case (ctl.op)
            pstt_pkg::OP_TICK:
            begin
                if (in_slot.id != '0)
                begin
                    if (cnt_inc >= in_slot.period)
                    begin
                        fire            = 1'b1;
                        slot_next.count = '0;
                    end
                    else
                    begin
                        slot_next.count = cnt_inc;
                    end
                end
            end
            pstt_pkg::OP_WRITE:
            begin
                if (ctl.hit)
                begin
                    slot_next.id     = ctl.id;
                    slot_next.count  = '0;
                    slot_next.period = ctl.period;
                end
            end
            pstt_pkg::OP_CLRID:
            begin
                if (ctl.hit)
                    slot_next.id = '0;
            end
            pstt_pkg::OP_CLRCT:
            begin
                if (ctl.hit)
                    slot_next.count = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else if (shift)
            slot_reg <= slot_next;
    end

endmodule

// ----- rtl/pstt_ring.sv -----
module pstt_ring
#(
    parameter int SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  pstt_pkg::cell_ctl_t ctl,
    output pstt_pkg::slot_t     head,
    output logic                fire
);

    pstt_pkg::slot_t chain [SLOTS];
    logic            unused_fire [SLOTS];

    // The last cell takes the head slot and operates on it; other cells only rotate
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            pstt_pkg::cell_ctl_t c;
            assign c = (g == SLOTS - 1) ? ctl : '0;
            pstt_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .ctl      (c),
                .in_slot  (chain[(g + 1) % SLOTS]),
                .out_slot (chain[g]),
                .fire     (unused_fire[g])
            );
        end
    endgenerate

    assign head = chain[0];
    assign fire = unused_fire[SLOTS - 1];

endmodule

// ----- rtl/periodic_software_timer_table.sv -----
// One item is accepted only while idle and is worked on alone, one slot a cycle.
// A 20 ms tick walks the fast ring then the real-time ring; a 1 s tick walks the slow ring
// once, then the drain and wait states lead back to idle. Requests walk a search pass then
// an update pass, searching the fast ring too when unregister or reset misses the slow ring,
// then pass the ack and wait states; id 0 goes straight to the ack. A pending fire holds the
// ring while the output stalls. Reset empties all slots and clears every count and period.
module periodic_software_timer_table
#(
    parameter int SLOTS   = 16,
    parameter int TICK_MS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // handler_id, period_ms
    input  logic [2:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fired_id, slot_index, ok
    output logic [1:0]  m_tuser,   // event_kind
    output logic        m_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FAST_MAX = 4095;
    localparam int SLOW_MAX = 127;

    // Reciprocal constants: the rounded sums stay below 2**17
    localparam int     RND_K = 17 + $clog2(TICK_MS);
    localparam longint RND_M = ((longint'(1) << RND_K) + longint'(TICK_MS) - 1) /
                               longint'(TICK_MS);
    localparam int     SEC_K = 27;
    localparam longint SEC_M = ((longint'(1) << SEC_K) + 999) / 1000;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_ACK    = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;

    // Ring select
    localparam logic [1:0] R_FAST = 2'd0;
    localparam logic [1:0] R_SLOW = 2'd1;
    localparam logic [1:0] R_RT   = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  req_reg;
    logic [15:0] id_reg;
    logic [11:0] per_reg;
    logic [1:0]  ring_reg, ring_next;
    logic        pass_reg, pass_next;       // 0 search, 1 update
    logic [SW-1:0] pos_reg, pos_next;
    logic        found_reg, found_next;
    logic [SW-1:0] hit_reg, hit_next;
    logic        efound_reg, efound_next;
    logic [SW-1:0] empty_reg, empty_next;
    logic [5:0]  nres_reg, nres_next;

    // Pending fire held one item deep; the ring stalls while it cannot be passed on
    logic        pend_reg;
    logic [1:0]  pend_kind_reg;
    logic [15:0] pend_id_reg;
    logic [3:0]  pend_slot_reg;

    logic        ov_reg;
    logic [1:0]  ov_kind_reg;
    logic [15:0] ov_id_reg;
    logic [3:0]  ov_slot_reg;
    logic        ov_ok_reg;
    logic        ov_last_reg;

    pstt_pkg::cell_ctl_t ctl_f, ctl_s, ctl_r, ctl;
    pstt_pkg::slot_t     head_f, head_s, head_r, head;
    logic                fire_f, fire_s, fire_r, fire;
    logic                sh_f, sh_s, sh_r, step;
    logic                out_free;
    logic                take, drain_take, ack_take, ov_load;

    logic [15:0] in_id, in_ms;
    logic [16:0] fsum;
    logic [34:0] fprod;
    logic [16:0] fq;
    logic [16:0] ssum;
    logic [34:0] sprod;
    logic [16:0] sqq;
    logic [6:0]  sq;
    logic [11:0] fper, sper;

    assign in_id = s_tdata[15:0];
    assign in_ms = s_tdata[31:16];

    // Period rounding by reciprocal multiplication
    assign fsum  = {1'b0, in_ms} + 17'(TICK_MS / 2);
    assign fprod = {18'd0, fsum} * 35'(RND_M);
    assign fq    = 17'(fprod >> RND_K);
    assign fper  = (fq > 17'(FAST_MAX)) ? 12'(FAST_MAX) : fq[11:0];

    assign ssum  = {1'b0, in_ms} + 17'd500;
    assign sprod = {18'd0, ssum} * 35'(SEC_M);
    assign sqq   = 17'(sprod >> SEC_K);
    assign sq    = (sqq > 17'(SLOW_MAX)) ? 7'(SLOW_MAX) : sqq[6:0];
    assign sper  = {5'd0, sq};

    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_free = !ov_reg || m_tready;

    assign m_tvalid = ov_reg;
    assign m_tuser  = ov_kind_reg;
    assign m_tlast  = ov_last_reg;
    assign m_tdata  = {3'd0, ov_ok_reg, ov_slot_reg, ov_id_reg};

    always_comb
    begin
        case (ring_reg)
            R_SLOW:  head = head_s;
            R_RT:    head = head_r;
            default: head = head_f;
        endcase
        case (ring_reg)
            R_SLOW:  fire = fire_s;
            R_RT:    fire = fire_r;
            default: fire = fire_f;
        endcase
    end

    // Control for the working cell of the active ring
    always_comb
    begin
        logic tick;
        logic [SW-1:0] p;
        tick   = (req_reg == pstt_pkg::REQ_TICK20) || (req_reg == pstt_pkg::REQ_TICK1S);
        p      = pos_reg;
        ctl    = '0;
        ctl.id = id_reg;
        ctl.period = per_reg;
        ctl.cmax   = (ring_reg == R_SLOW) ? 12'(SLOW_MAX) : 12'(FAST_MAX);
        if (state_reg == ST_WALK)
        begin
            if (tick)
            begin
                ctl.op = pstt_pkg::OP_TICK;
            end
            else if (pass_reg)
            begin
                case (req_reg)
                    pstt_pkg::REQ_REG, pstt_pkg::REQ_REG_RT:
                    begin
                        ctl.op  = pstt_pkg::OP_WRITE;
                        ctl.hit = found_reg ? (p == hit_reg) : (efound_reg && p == empty_reg);
                    end
                    pstt_pkg::REQ_UNREG, pstt_pkg::REQ_UNREG_RT:
                    begin
                        ctl.op  = pstt_pkg::OP_CLRID;
                        ctl.hit = found_reg && (p == hit_reg);
                    end
                    default:
                    begin
                        ctl.op  = pstt_pkg::OP_CLRCT;
                        ctl.hit = found_reg && (p == hit_reg);
                    end
                endcase
            end
        end
    end

    // Advance the ring unless a held fire cannot move on to the output
    assign step  = (state_reg == ST_WALK) && (!pend_reg || out_free);
    assign ctl_f = (ring_reg == R_FAST) ? ctl : '0;
    assign ctl_s = (ring_reg == R_SLOW) ? ctl : '0;
    assign ctl_r = (ring_reg == R_RT)   ? ctl : '0;
    assign sh_f  = step && (ring_reg == R_FAST);
    assign sh_s  = step && (ring_reg == R_SLOW);
    assign sh_r  = step && (ring_reg == R_RT);

    assign take       = step && fire && (nres_reg != 6'(pstt_pkg::MAXRES)) &&
                        (req_reg == pstt_pkg::REQ_TICK20 || req_reg == pstt_pkg::REQ_TICK1S);
    assign drain_take = (state_reg == ST_DRAIN) && pend_reg && out_free;
    assign ack_take   = (state_reg == ST_ACK) && out_free;
    assign ov_load    = (take && pend_reg) || drain_take || ack_take;

    pstt_ring #(.SLOTS(SLOTS)) u_fast
    (
        .clk(clk), .rst_n(rst_n), .shift(sh_f), .ctl(ctl_f), .head(head_f), .fire(fire_f)
    );
    pstt_ring #(.SLOTS(SLOTS)) u_slow
    (
        .clk(clk), .rst_n(rst_n), .shift(sh_s), .ctl(ctl_s), .head(head_s), .fire(fire_s)
    );
    pstt_ring #(.SLOTS(SLOTS)) u_rt
    (
        .clk(clk), .rst_n(rst_n), .shift(sh_r), .ctl(ctl_r), .head(head_r), .fire(fire_r)
    );

    // Sequencer
    always_comb
    begin
        logic tick;
        logic wrap;
        logic [SW-1:0] p;
        tick        = (req_reg == pstt_pkg::REQ_TICK20) || (req_reg == pstt_pkg::REQ_TICK1S);
        p           = pos_reg;
        wrap        = (pos_reg == SW'(SLOTS - 1));
        state_next  = state_reg;
        ring_next   = ring_reg;
        pass_next   = pass_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        efound_next = efound_reg;
        empty_next  = empty_reg;
        nres_next   = nres_reg;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_WALK:
            begin
                if (step)
                begin
                    pos_next = wrap ? '0 : pos_reg + 1'b1;
                    if (!tick && !pass_reg)
                    begin
                        if (!found_reg && head.id == id_reg)
                        begin
                            found_next = 1'b1;
                            hit_next   = p;
                        end
                        if (!efound_reg && head.id == '0)
                        begin
                            efound_next = 1'b1;
                            empty_next  = p;
                        end
                    end
                    if (take)
                        nres_next = nres_reg + 1'b1;
                    if (wrap)
                    begin
                        if (tick)
                        begin
                            if (ring_reg == R_FAST)
                                ring_next = R_RT;
                            else
                                state_next = ST_DRAIN;
                        end
                        else if (!pass_reg)
                        begin
                            if ((req_reg == pstt_pkg::REQ_UNREG ||
                                 req_reg == pstt_pkg::REQ_RESET) &&
                                ring_reg == R_SLOW && !found_next)
                            begin
                                ring_next   = R_FAST;
                            end
                            else
                            begin
                                pass_next = 1'b1;
                            end
                        end
                        else
                        begin
                            state_next = ST_ACK;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!pend_reg)
                    state_next = ST_WAIT;
            end
            ST_ACK:
            begin
                if (out_free)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        if (s_tvalid && s_tready)
        begin
            state_next  = ST_WALK;
            pass_next   = 1'b0;
            pos_next    = '0;
            found_next  = 1'b0;
            efound_next = 1'b0;
            hit_next    = '0;
            empty_next  = '0;
            nres_next   = '0;
            case (s_tuser)
                pstt_pkg::REQ_TICK20:   ring_next = R_FAST;
                pstt_pkg::REQ_TICK1S:   ring_next = R_SLOW;
                pstt_pkg::REQ_REG:      ring_next = (in_ms >= 16'd1000) ? R_SLOW : R_FAST;
                pstt_pkg::REQ_UNREG, pstt_pkg::REQ_RESET: ring_next = R_SLOW;
                default:                ring_next = R_RT;
            endcase
            if (s_tuser != pstt_pkg::REQ_TICK20 && s_tuser != pstt_pkg::REQ_TICK1S &&
                in_id == '0)
                state_next = ST_ACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ring_reg   <= R_FAST;
            pass_reg   <= 1'b0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            hit_reg    <= '0;
            efound_reg <= 1'b0;
            empty_reg  <= '0;
            nres_reg   <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            ring_reg   <= ring_next;
            pass_reg   <= pass_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            hit_reg    <= hit_next;
            efound_reg <= efound_next;
            empty_reg  <= empty_next;
            nres_reg   <= nres_next;
            state_reg  <= state_next;
            if (ov_load)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
            // Hold one fire back so the final one can be flagged last
            if (take)
                pend_reg <= 1'b1;
            else if (drain_take)
                pend_reg <= 1'b0;
        end
    end

    // Request and output stage data
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg     <= s_tuser;
            id_reg      <= in_id;
            per_reg     <= (s_tuser == pstt_pkg::REQ_REG && in_ms >= 16'd1000) ? sper : fper;
        end
        if (take)
        begin
            pend_kind_reg <= (ring_reg == R_RT) ? pstt_pkg::EV_RT : pstt_pkg::EV_POSTED;
            pend_id_reg   <= head.id;
            pend_slot_reg <= 4'(pos_reg);
            if (pend_reg)
            begin
                ov_kind_reg <= pend_kind_reg;
                ov_id_reg   <= pend_id_reg;
                ov_slot_reg <= pend_slot_reg;
                ov_ok_reg   <= 1'b1;
                ov_last_reg <= 1'b0;
            end
        end
        else if (drain_take)
        begin
            ov_kind_reg <= pend_kind_reg;
            ov_id_reg   <= pend_id_reg;
            ov_slot_reg <= pend_slot_reg;
            ov_ok_reg   <= 1'b1;
            ov_last_reg <= 1'b1;
        end
        else if (ack_take)
        begin
            ov_kind_reg <= pstt_pkg::EV_ACK;
            ov_id_reg   <= id_reg;
            ov_ok_reg   <= (id_reg != '0) && (found_reg ||
                           ((req_reg == pstt_pkg::REQ_REG || req_reg == pstt_pkg::REQ_REG_RT)
                            && efound_reg));
            ov_slot_reg <= (id_reg == '0) ? 4'd0 : found_reg ? 4'(hit_reg) :
                           ((req_reg == pstt_pkg::REQ_REG || req_reg == pstt_pkg::REQ_REG_RT)
                            && efound_reg) ? 4'(empty_reg) : 4'd0;
            ov_last_reg <= 1'b1;
        end
    end

endmodule
